### src/xtea_pkg.sv
// ---------------------------------------------------------------------------
// xtea_pkg
// Shared types and codes for the pipelined XTEA block cipher.
// ---------------------------------------------------------------------------
package xtea_pkg;

  // operation selector codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // number of key words and width of the key word index
  localparam int KEY_WORDS   = 4;
  localparam int KEY_IDX_W   = 2;
  localparam int WORD_W      = 32;

  // four key words, word 0 in the lowest slice
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // one block in flight with its operation
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } blk_t;

endpackage

### src/xtea_stage.sv
// ---------------------------------------------------------------------------
// xtea_stage
// One registered half round of XTEA; encrypt or decrypt chosen per item.
// ---------------------------------------------------------------------------
module xtea_stage #(
  parameter int STAGE_ID    = 0,
  parameter int ROUND_COUNT = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  xtea_pkg::blk_t in_blk,
  input  xtea_pkg::key_t key,
  output logic          out_valid_r,
  output xtea_pkg::blk_t out_blk_r
);

  localparam logic [31:0] DELTA     = 32'h9E3779B9;
  localparam int          KEY_SHIFT = 11;
  localparam bit          EVEN      = (STAGE_ID % 2) == 0;
  localparam int          ROUND     = STAGE_ID / 2;
  localparam int          ENC_MUL   = EVEN ? ROUND : ROUND + 1;
  localparam int          DEC_MUL   = EVEN ? ROUND_COUNT - ROUND : ROUND_COUNT - ROUND - 1;
  localparam logic [63:0] ENC_PROD  = 64'(ENC_MUL) * 64'(DELTA);
  localparam logic [63:0] DEC_PROD  = 64'(DEC_MUL) * 64'(DELTA);
  localparam logic [31:0] ENC_SUM   = ENC_PROD[31:0];
  localparam logic [31:0] DEC_SUM   = DEC_PROD[31:0];
  localparam logic [xtea_pkg::KEY_IDX_W-1:0] ENC_IDX =
    EVEN ? ENC_SUM[1:0] : ENC_SUM[KEY_SHIFT+1:KEY_SHIFT];
  localparam logic [xtea_pkg::KEY_IDX_W-1:0] DEC_IDX =
    EVEN ? DEC_SUM[KEY_SHIFT+1:KEY_SHIFT] : DEC_SUM[1:0];

  function automatic logic [31:0] xt_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  logic          dec;
  logic          upd_v0;
  logic [31:0]   src;
  logic [31:0]   tgt;
  logic [31:0]   keyed;
  logic [31:0]   f;
  logic [31:0]   new_word;
  xtea_pkg::blk_t blk_nxt;

  // half-round datapath: mix of one word, keyed sum, add or subtract into the other
  always_comb begin
    dec    = (in_blk.op == xtea_pkg::OP_DECRYPT);
    // even stages touch v0 on encrypt and v1 on decrypt, odd stages the opposite
    upd_v0 = EVEN ? !dec : dec;
    src    = upd_v0 ? in_blk.v1 : in_blk.v0;
    tgt    = upd_v0 ? in_blk.v0 : in_blk.v1;
    keyed  = dec ? (DEC_SUM + key[DEC_IDX]) : (ENC_SUM + key[ENC_IDX]);
    f      = xt_mix(src) ^ keyed;
    new_word = dec ? (tgt - f) : (tgt + f);
    blk_nxt  = in_blk;
    if (upd_v0) begin
      blk_nxt.v0 = new_word;
    end else begin
      blk_nxt.v1 = new_word;
    end
  end

  // stage valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_blk_r <= blk_nxt;
    end
  end

endmodule

### src/xtea_block_cipher.sv
// ---------------------------------------------------------------------------
// xtea_block_cipher
// Fully pipelined XTEA encrypt/decrypt of one 64-bit block per item.
// ---------------------------------------------------------------------------
// usage:
//   input channel in_*: in_tdata = {block_second, block_first}, in_tuser is
//   the operation (0 encrypt, 1 decrypt). result channel out_*: out_tdata =
//   {result_second, result_first}.
//   key words are written through cfg_we/cfg_index/cfg_wdata; a write takes
//   effect at the next edge and applies to every item in the pipe, so the user
//   must change keys only while the pipe is empty; the block does not enforce it.
//   pipeline: one register stage per half round from acceptance to out_tvalid.
//   throughput: one item per cycle while the output is not stalled; every stage holds its own item.
//   stall: when out_tvalid is high and out_tready low the whole pipe holds
//   and in_tready drops; an empty output stage lets the pipe advance anyway.
//   reset (rst_n low, synchronous): all stage valid bits and key words clear.
// ---------------------------------------------------------------------------
module xtea_block_cipher #(
  parameter int ROUND_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] block_first, [63:32] block_second
  input  logic        in_tuser,   // [0] operation
  // result item channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] result_first, [63:32] result_second
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int STAGES = 2 * ROUND_COUNT;

  xtea_pkg::key_t key_r;
  logic           en;
  logic [STAGES:0] valid;
  xtea_pkg::blk_t  blk [STAGES+1];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  // pipe advances unless a finished item is stalled at the output
  assign en        = out_tready || !valid[STAGES];
  assign in_tready = en;

  // stage 0 input
  assign valid[0]   = in_tvalid;
  assign blk[0].op  = in_tuser;
  assign blk[0].v0  = in_tdata[31:0];
  assign blk[0].v1  = in_tdata[63:32];

  // half-round stage chain
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    xtea_stage #(
      .STAGE_ID    (s),
      .ROUND_COUNT (ROUND_COUNT)
    ) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (valid[s]),
      .in_blk      (blk[s]),
      .key         (key_r),
      .out_valid_r (valid[s+1]),
      .out_blk_r   (blk[s+1])
    );
  end

  // result channel
  assign out_tvalid = valid[STAGES];
  assign out_tdata  = {blk[STAGES].v1, blk[STAGES].v0};

`ifndef ASSERT_OFF
  // an accepted item occupies the first stage in the next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> valid[1])
    else $error("accepted item missing from first stage");

  // a held pipe keeps all valid bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !en) |=> $stable(valid[STAGES:1]))
    else $error("stage valid bits moved during stall");

  // a stalled result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // a key write lands in the addressed word
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cfg_we) |=> (key_r[$past(cfg_index)] == $past(cfg_wdata)))
    else $error("key write lost");
`endif

endmodule
